FILE: rtl/lfucd_pkg.sv
// ----------------------------------------------------------------------------
// lfucd_pkg
// shared types and constants for the lfu chunk cache directory
// ----------------------------------------------------------------------------
package lfucd_pkg;

  localparam int unsigned TAG_W    = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned OUT_WAY_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(1);

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [TAG_W-1:0]    chunk_index;
    logic [HANDLE_W-1:0] fill_handle;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    logic [HANDLE_W-1:0]  handle_out;
    logic                 evicted_valid;
    logic [TAG_W-1:0]     evicted_index;
  } rsp_t;

endpackage

FILE: rtl/lfucd_way_select.sv
// ----------------------------------------------------------------------------
// lfucd_way_select
// parallel tag match and victim pick (first empty way, else lowest least-hit)
// ----------------------------------------------------------------------------
module lfucd_way_select
  import lfucd_pkg::*;
#(
  parameter int unsigned WAYS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [WAYS-1:0]    way_valid,
  input  logic [TAG_W-1:0]   way_tag [WAYS],
  input  logic [COUNT_W-1:0] way_hit_count [WAYS],
  input  logic [TAG_W-1:0]   chunk_index,
  output logic [WAYS-1:0]    hit_onehot,
  output logic [WAYS-1:0]    victim_onehot
);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] empty_first;
  logic [WAYS-1:0] least_hit;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = way_valid[i] && (way_tag[i] == chunk_index);
    end
  end

  // lowest set bit wins for both the hit and the empty way
  always_comb begin
    logic seen_hit;
    logic seen_empty;
    seen_hit   = 1'b0;
    seen_empty = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      hit_onehot[i]  = match[i] && !seen_hit;
      seen_hit       = seen_hit || match[i];
      empty_first[i] = !way_valid[i] && !seen_empty;
      seen_empty     = seen_empty || !way_valid[i];
    end
  end

  // way i is the least-hit winner when it beats every lower way strictly and
  // ties or beats every higher way; all compares run side by side
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      least_hit[i] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        if (j < i && !(way_hit_count[i] < way_hit_count[j])) begin
          least_hit[i] = 1'b0;
        end
        if (j > i && !(way_hit_count[i] <= way_hit_count[j])) begin
          least_hit[i] = 1'b0;
        end
      end
    end
  end

  assign victim_onehot = (&way_valid) ? least_hit : empty_first;

  a_hit_onehot0 : assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_onehot))
    else $error("more than one hit way selected");

  a_hit_needs_match : assert property (@(posedge clk) disable iff (rst)
    (|match) == (|hit_onehot))
    else $error("hit select disagrees with tag match");

  a_victim_empty_first : assert property (@(posedge clk) disable iff (rst)
    !(&way_valid) |-> ((victim_onehot & way_valid) == '0))
    else $error("victim is a valid way while an empty way exists");

endmodule

FILE: rtl/lfu_chunk_cache_directory.sv
// ----------------------------------------------------------------------------
// lfu_chunk_cache_directory
// fully associative chunk-to-handle directory with lfu replacement
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready/req) carries one item: a lookup or a fill
//   of a chunk index. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one
//   item per request, in request order.
//   a lookup reports hit, the lowest matching way and its handle, and bumps
//   that way's hit count (saturating). a fill takes the first empty way, or
//   the lowest way with the fewest hits, sets its count to 1 and reports the
//   evicted index and handle.
//   a request passes the request register, then the response register, before
//   rsp_valid rises; a stalled receiver can hold it in between. throughput:
//   one item per cycle while the receiver takes each response; the
//   tag compare and least-hit search are a single pass of parallel compares
//   across all ways, and the way state updates as an item moves into the
//   response register, so the next item already sees it.
//   a stalled receiver holds the response register; the request register
//   still takes one more item, then req_ready drops until rsp_ready returns.
//   reset clears all valid bits, also in both pipeline registers; tag, handle and
//   count storage is only read after a fill has written it.
// ----------------------------------------------------------------------------
module lfu_chunk_cache_directory
  import lfucd_pkg::*;
#(
  parameter int unsigned WAYS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // request register
  logic req_q_valid;
  req_t req_q;

  // way storage
  logic [WAYS-1:0]     way_valid;
  logic [TAG_W-1:0]    way_tag [WAYS];
  logic [HANDLE_W-1:0] way_handle [WAYS];
  logic [COUNT_W-1:0]  way_hit_count [WAYS];

  logic [WAYS-1:0] hit_onehot;
  logic [WAYS-1:0] victim_onehot;
  logic            advance;
  logic            is_fill;
  logic            any_hit;
  logic            evict;
  logic [WAY_W-1:0]    hit_idx;
  logic [WAY_W-1:0]    victim_idx;
  logic [HANDLE_W-1:0] hit_handle;
  logic [HANDLE_W-1:0] victim_handle;
  logic [TAG_W-1:0]    victim_tag;
  rsp_t rsp_next;

  // item moves from request register to response register
  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;
  assign is_fill   = (req_q.op == OP_FILL);

  lfucd_way_select #(
    .WAYS (WAYS)
  ) u_select (
    .clk           (clk),
    .rst           (rst),
    .way_valid     (way_valid),
    .way_tag       (way_tag),
    .way_hit_count (way_hit_count),
    .chunk_index   (req_q.chunk_index),
    .hit_onehot    (hit_onehot),
    .victim_onehot (victim_onehot)
  );

  // one-hot and-or readout, every way read at its own fixed place
  always_comb begin
    hit_idx       = '0;
    victim_idx    = '0;
    hit_handle    = '0;
    victim_handle = '0;
    victim_tag    = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (hit_onehot[i]) begin
        hit_idx    = hit_idx | WAY_W'(i);
        hit_handle = hit_handle | way_handle[i];
      end
      if (victim_onehot[i]) begin
        victim_idx    = victim_idx | WAY_W'(i);
        victim_handle = victim_handle | way_handle[i];
        victim_tag    = victim_tag | way_tag[i];
      end
    end
  end

  assign any_hit = |hit_onehot;
  // an empty way always wins, so a fill evicts only when every way is valid
  assign evict   = &way_valid;

  always_comb begin
    rsp_next = '0;
    if (is_fill) begin
      rsp_next.way = OUT_WAY_W'(victim_idx);
      if (evict) begin
        rsp_next.evicted_valid = 1'b1;
        rsp_next.handle_out    = victim_handle;
        rsp_next.evicted_index = victim_tag;
      end
    end else if (any_hit) begin
      rsp_next.hit        = 1'b1;
      rsp_next.way        = OUT_WAY_W'(hit_idx);
      rsp_next.handle_out = hit_handle;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      way_valid   <= '0;
    end else begin
      if (req_ready) begin
        req_q_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (advance && is_fill) begin
        way_valid <= way_valid | victim_onehot;
      end
    end
  end

  // payload registers and way storage
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_q <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (advance && is_fill && victim_onehot[i]) begin
        way_tag[i]       <= req_q.chunk_index;
        way_handle[i]    <= req_q.fill_handle;
        way_hit_count[i] <= COUNT_INIT;
      end else if (advance && !is_fill && hit_onehot[i] &&
                   way_hit_count[i] != COUNT_MAX) begin
        way_hit_count[i] <= way_hit_count[i] + COUNT_W'(1);
      end
    end
  end

  a_fill_sets_valid : assert property (@(posedge clk) disable iff (rst)
    (advance && is_fill) |=> way_valid[$past(victim_idx)])
    else $error("filled way not marked valid");

  a_no_evict_when_room : assert property (@(posedge clk) disable iff (rst)
    (advance && is_fill && !(&way_valid)) |=> !rsp.evicted_valid)
    else $error("eviction reported while an empty way existed");

  a_hit_not_evict : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> !rsp.evicted_valid)
    else $error("response shows both hit and eviction");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> !$past(advance))
    else $error("response register overwritten while stalled");

endmodule
